[rtl/core/nmea_cap_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_cap_pkg
// Shared constants and types of the NMEA sentence capture block: field
// widths, result codes, framing characters and register indexes.
// ----------------------------------------------------------------------------
package nmea_cap_pkg;

    // Field widths of the item channels
    localparam int BYTE_W  = 8;
    localparam int RIDX_W  = 7;
    localparam int EVENT_W = 3;
    localparam int LEN_W   = 8;

    // Configuration port
    localparam int TAG_W     = 40;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_TAG_FIRST  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TAG_SECOND = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TAG_SELECT = 2'd2;

    // Reset tags: "GPRMC" and "GPGGA"
    localparam logic [TAG_W-1:0] TAG_FIRST_RST  = 40'h4750524D43;
    localparam logic [TAG_W-1:0] TAG_SECOND_RST = 40'h4750474741;

    // Input item kinds
    localparam logic KIND_RX   = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Framing characters
    localparam logic [BYTE_W-1:0] CHAR_START = 8'h24;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;

    // Result event codes
    typedef logic [EVENT_W-1:0] event_t;

    localparam event_t EV_HUNT     = 3'd0;
    localparam event_t EV_STORED   = 3'd1;
    localparam event_t EV_CAPTURED = 3'd2;
    localparam event_t EV_UNWANTED = 3'd3;
    localparam event_t EV_OVERFLOW = 3'd4;
    localparam event_t EV_READ     = 3'd5;

    // Sentence buffer access control
    typedef struct packed {
        logic we;
        logic re;
    } mem_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/nmea_cap_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_cap_if
// Valid/ready channels of the NMEA sentence capture block: the input item
// channel and the result item channel.
// ----------------------------------------------------------------------------
interface nmea_cap_in_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [nmea_cap_pkg::BYTE_W-1:0]   rx_byte;
    logic [nmea_cap_pkg::RIDX_W-1:0]   read_index;

    modport source (output valid, kind, rx_byte, read_index, input ready);
    modport sink   (input valid, kind, rx_byte, read_index, output ready);
endinterface

interface nmea_cap_out_if;
    logic                              valid;
    logic                              ready;
    logic [nmea_cap_pkg::EVENT_W-1:0]  event_res;
    logic [nmea_cap_pkg::LEN_W-1:0]    captured_length;
    logic [nmea_cap_pkg::BYTE_W-1:0]   read_data;

    modport source (output valid, event_res, captured_length, read_data, input ready);
    modport sink   (input valid, event_res, captured_length, read_data, output ready);
endinterface

`default_nettype wire

[rtl/core/nmea_cap_buf.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_cap_buf
// Two-bank sentence buffer: one write port and one read port with
// registered read data. The bank bit is the top address bit.
// ----------------------------------------------------------------------------
module nmea_cap_buf #(
    parameter int DEPTH = 256
) (
    input  wire                                clk,
    input  nmea_cap_pkg::mem_ctrl_t            ctrl,
    input  wire [$clog2(DEPTH)-1:0]            waddr,
    input  wire [nmea_cap_pkg::BYTE_W-1:0]     wdata,
    input  wire [$clog2(DEPTH)-1:0]            raddr,
    output logic [nmea_cap_pkg::BYTE_W-1:0]    rdata
);

    logic [nmea_cap_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [nmea_cap_pkg::BYTE_W-1:0] rdata_reg;

    // Write the work bank, read the captured bank
    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctrl.re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/nmea_sentence_capture.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_sentence_capture
// Filters NMEA 0183 sentences out of a received byte stream and keeps the
// latest sentence whose header matches the selected tag.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one item per handshake: a received UART byte (kind 0) or
//          a read of one captured sentence byte (kind 1).
//   out_ch returns exactly one result item per input item, in order: event
//          code, current captured length and read byte.
//   cfg_we/cfg_index/cfg_data write the two tags and the tag select; write
//          them only while no item is in flight.
// A result is valid in the cycle after acceptance; one item is taken
// every cycle while out_ch is drained. The output register is the only
// buffering: in_ch.ready is high whenever that register is empty or being
// taken, so a stall on out_ch holds the result and blocks in_ch for as long
// as it lasts. The captured sentence lives in one bank of a two-bank buffer
// whose read data is registered straight into the result; a capture swaps
// the banks. Reset empties the capture (length 0), restarts hunting for '$'
// and loads the tags "GPRMC" and "GPGGA" with the first one selected.
// ----------------------------------------------------------------------------
module nmea_sentence_capture #(
    parameter int BUF_DEPTH = 128,
    parameter int TAG_LEN   = 5
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    nmea_cap_in_if.sink                            in_ch,
    nmea_cap_out_if.source                         out_ch,
    input  wire                                    cfg_we,
    input  wire [nmea_cap_pkg::REG_IDX_W-1:0]      cfg_index,
    input  wire [nmea_cap_pkg::TAG_W-1:0]          cfg_data
);

    localparam int IW   = $clog2(BUF_DEPTH);
    localparam int CW   = $clog2(BUF_DEPTH + 1);
    localparam int HW   = TAG_LEN * 8;
    localparam int XW   = (CW > nmea_cap_pkg::RIDX_W) ? CW : nmea_cap_pkg::RIDX_W;

    // Configuration registers
    logic [nmea_cap_pkg::TAG_W-1:0]  tag_first_reg;
    logic [nmea_cap_pkg::TAG_W-1:0]  tag_second_reg;
    logic                            tag_select_reg;

    // Sentence tracking state
    logic [IW-1:0]                   wp_reg, wp_next;
    logic [HW-1:0]                   hdr_reg, hdr_next, hdr_upd;
    logic [nmea_cap_pkg::BYTE_W-1:0] prev_reg, prev_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic                            bank_reg, bank_next;

    // Result register
    logic                            out_valid_reg;
    nmea_cap_pkg::event_t            ev_reg, ev_next;
    logic [nmea_cap_pkg::LEN_W-1:0]  len_reg;
    logic                            rd_ok_reg, rd_ok_next;

    // Buffer access
    nmea_cap_pkg::mem_ctrl_t         mem_ctrl;
    logic [IW:0]                     mem_waddr;
    logic [IW:0]                     mem_raddr;
    logic [nmea_cap_pkg::BYTE_W-1:0] mem_rdata;

    logic                            accept;
    logic                            in_ready;
    logic                            is_end;
    logic                            hdr_full;
    logic                            match_first;
    logic                            match_second;
    logic                            want;
    logic                            capture;

    // Take a new item whenever the result register is free or drains
    assign in_ready    = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = in_ready;
    assign accept      = in_ch.valid && in_ready;

    // Header shift and sentence end detection
    assign hdr_upd      = (wp_reg <= IW'(TAG_LEN)) ? HW'({hdr_reg, in_ch.rx_byte}) : hdr_reg;
    assign is_end       = (in_ch.rx_byte == nmea_cap_pkg::CHAR_LF)
                       && (prev_reg == nmea_cap_pkg::CHAR_CR);
    assign hdr_full     = wp_reg > IW'(TAG_LEN);
    assign match_first  = hdr_upd == HW'(tag_first_reg);
    assign match_second = hdr_upd == HW'(tag_second_reg);
    assign want         = hdr_full && (match_first ? !tag_select_reg
                                                   : (match_second && tag_select_reg));

    // Advance the sentence state for one item
    always_comb
    begin
        wp_next      = wp_reg;
        hdr_next     = hdr_reg;
        prev_next    = prev_reg;
        cnt_next     = cnt_reg;
        bank_next    = bank_reg;
        ev_next      = nmea_cap_pkg::EV_HUNT;
        rd_ok_next   = 1'b0;
        capture      = 1'b0;
        mem_ctrl.we  = 1'b0;
        mem_ctrl.re  = 1'b0;
        mem_waddr    = {~bank_reg, wp_reg};
        mem_raddr    = {bank_reg, IW'(in_ch.read_index)};

        if (accept)
        begin
            if (in_ch.kind == nmea_cap_pkg::KIND_READ)
            begin
                ev_next     = nmea_cap_pkg::EV_READ;
                mem_ctrl.re = 1'b1;
                rd_ok_next  = (XW'(in_ch.read_index) < XW'(cnt_reg))
                           && (XW'(in_ch.read_index) < XW'(BUF_DEPTH));
            end
            else if (wp_reg == '0)
            begin
                // Hunt for the start character
                if (in_ch.rx_byte == nmea_cap_pkg::CHAR_START)
                begin
                    mem_ctrl.we = 1'b1;
                    prev_next   = in_ch.rx_byte;
                    hdr_next    = '0;
                    wp_next     = IW'(1);
                    ev_next     = nmea_cap_pkg::EV_STORED;
                end
            end
            else
            begin
                mem_ctrl.we = 1'b1;
                hdr_next    = hdr_upd;
                prev_next   = in_ch.rx_byte;
                if (is_end)
                begin
                    wp_next = '0;
                    if (want)
                    begin
                        capture   = 1'b1;
                        cnt_next  = CW'(wp_reg) + CW'(1);
                        bank_next = ~bank_reg;
                        ev_next   = nmea_cap_pkg::EV_CAPTURED;
                    end
                    else
                    begin
                        ev_next = nmea_cap_pkg::EV_UNWANTED;
                    end
                end
                else if (wp_reg == IW'(BUF_DEPTH - 1))
                begin
                    // Drop the sentence, keep the capture
                    wp_next = '0;
                    ev_next = nmea_cap_pkg::EV_OVERFLOW;
                end
                else
                begin
                    wp_next = wp_reg + IW'(1);
                    ev_next = nmea_cap_pkg::EV_STORED;
                end
            end
        end
    end

    // Control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_first_reg  <= nmea_cap_pkg::TAG_FIRST_RST;
            tag_second_reg <= nmea_cap_pkg::TAG_SECOND_RST;
            tag_select_reg <= 1'b0;
            wp_reg         <= '0;
            hdr_reg        <= '0;
            prev_reg       <= '0;
            cnt_reg        <= '0;
            bank_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    nmea_cap_pkg::REG_TAG_FIRST:  tag_first_reg  <= cfg_data;
                    nmea_cap_pkg::REG_TAG_SECOND: tag_second_reg <= cfg_data;
                    nmea_cap_pkg::REG_TAG_SELECT: tag_select_reg <= cfg_data[0];
                    default:                      ;
                endcase
            end
            wp_reg   <= wp_next;
            hdr_reg  <= hdr_next;
            prev_reg <= prev_next;
            cnt_reg  <= cnt_next;
            bank_reg <= bank_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result payload until the next item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_reg    <= ev_next;
            len_reg   <= nmea_cap_pkg::LEN_W'(cnt_next);
            rd_ok_reg <= rd_ok_next;
        end
    end

    // Two-bank sentence buffer; each bank spans the full work address range
    nmea_cap_buf #(
        .DEPTH (2 << IW)
    ) u_buf (
        .clk   (clk),
        .ctrl  (mem_ctrl),
        .waddr (mem_waddr),
        .wdata (in_ch.rx_byte),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Drive the result channel
    assign out_ch.valid           = out_valid_reg;
    assign out_ch.event_res       = ev_reg;
    assign out_ch.captured_length = len_reg;
    assign out_ch.read_data       = rd_ok_reg ? mem_rdata : '0;

`ifndef SYNTHESIS
    // A capture swaps the buffer banks
    a_capture_swaps: assert property (@(posedge clk) disable iff (!rst_n)
        capture |=> (bank_reg != $past(bank_reg)))
        else $error("bank did not swap on capture");

    // The captured length only changes on a capture
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !capture |=> $stable(cnt_reg))
        else $error("captured length changed without a capture");

    // Only read replies carry buffer data
    a_read_data_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (ev_reg != nmea_cap_pkg::EV_READ)) |-> !rd_ok_reg)
        else $error("read data enabled on a received-byte result");
`endif

endmodule

`default_nettype wire

[tb/nmea_capture_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_capture_checker
// Watches the item channels and the register port of the sentence capture
// block. It keeps its own model of the hunt, the header match and the
// captured buffer, queues the expected result of every accepted input item
// and compares each accepted result with the oldest one, field by field.
// ----------------------------------------------------------------------------
module nmea_capture_checker
    import nmea_cap_pkg::*;
#(
    parameter int BUF_DEPTH = 128,
    parameter int TAG_LEN   = 5
) (
    input  wire                     clk,
    input  wire                     rst_n,
    nmea_cap_in_if                  in_ch,
    nmea_cap_out_if                 out_ch,
    input  wire                     cfg_we,
    input  wire [REG_IDX_W-1:0]     cfg_index,
    input  wire [TAG_W-1:0]         cfg_data,
    output int                      error_count,
    output int                      pending_count
);

    localparam logic [TAG_W-1:0] HDR_MASK = {TAG_W{1'b1}} >> (TAG_W - 8 * TAG_LEN);

    typedef struct packed {
        event_t              ev;
        logic [LEN_W-1:0]    len;
        logic [BYTE_W-1:0]   data;
    } capture_result_t;

    // Model state and register copies
    logic [BYTE_W-1:0] work_buf [BUF_DEPTH];
    logic [BYTE_W-1:0] cap_buf  [BUF_DEPTH];
    int                wr_pos;
    int                cap_len;
    logic [TAG_W-1:0]  hdr;
    logic [BYTE_W-1:0] last_byte;
    logic [TAG_W-1:0]  tag_first;
    logic [TAG_W-1:0]  tag_second;
    logic              tag_sel;

    capture_result_t   expected_results [$];
    capture_result_t   want;
    int                errors;

    // Advance the sentence model by one input item and return its result
    function capture_result_t capture_step(input logic k, input logic [BYTE_W-1:0] b,
                                           input logic [RIDX_W-1:0] ri);
        capture_result_t r;
        logic            wanted;
        int              pos;
        r.ev   = EV_HUNT;
        r.data = '0;
        if (k == KIND_READ)
        begin
            r.ev = EV_READ;
            if (ri < cap_len)
                r.data = cap_buf[ri];
        end
        else if (wr_pos == 0)
        begin
            if (b == CHAR_START)
            begin
                work_buf[0] = b;
                last_byte   = b;
                hdr         = '0;
                wr_pos      = 1;
                r.ev        = EV_STORED;
            end
        end
        else
        begin
            pos           = wr_pos;
            work_buf[pos] = b;
            if (pos <= TAG_LEN)
                hdr = ((hdr << 8) | b) & HDR_MASK;
            if (b == CHAR_LF && last_byte == CHAR_CR)
            begin
                // First tag wins over the second when both match
                wanted = 1'b0;
                if (pos > TAG_LEN && hdr == (tag_first & HDR_MASK))
                    wanted = (tag_sel == 1'b0);
                else if (pos > TAG_LEN && hdr == (tag_second & HDR_MASK))
                    wanted = (tag_sel == 1'b1);
                if (wanted)
                begin
                    cap_len = pos + 1;
                    for (int i = 0; i <= pos; i++)
                        cap_buf[i] = work_buf[i];
                    r.ev = EV_CAPTURED;
                end
                else
                    r.ev = EV_UNWANTED;
                wr_pos = 0;
            end
            else if (pos >= BUF_DEPTH - 1)
            begin
                // Drop the run-on sentence and hunt again
                wr_pos = 0;
                r.ev   = EV_OVERFLOW;
            end
            else
            begin
                wr_pos = pos + 1;
                r.ev   = EV_STORED;
            end
            last_byte = b;
        end
        r.len = cap_len[LEN_W-1:0];
        return r;
    endfunction

    // Compare results, track register writes, queue predictions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos     = 0;
            cap_len    = 0;
            hdr        = '0;
            last_byte  = '0;
            tag_first  = TAG_FIRST_RST;
            tag_second = TAG_SECOND_RST;
            tag_sel    = 1'b0;
            errors     = 0;
            expected_results.delete();
            error_count   <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with no expected result waiting");
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_ch.event_res !== want.ev)
                    begin
                        $error("event_res: expected %0d, actual %0d", want.ev,
                               out_ch.event_res);
                        errors++;
                    end
                    if (out_ch.captured_length !== want.len)
                    begin
                        $error("captured_length: expected %0d, actual %0d", want.len,
                               out_ch.captured_length);
                        errors++;
                    end
                    if (out_ch.read_data !== want.data)
                    begin
                        $error("read_data: expected 0x%02h, actual 0x%02h", want.data,
                               out_ch.read_data);
                        errors++;
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TAG_FIRST:  tag_first  = cfg_data;
                    REG_TAG_SECOND: tag_second = cfg_data;
                    REG_TAG_SELECT: tag_sel    = cfg_data[0];
                    default: ;
                endcase
            end

            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(capture_step(in_ch.kind, in_ch.rx_byte,
                                                        in_ch.read_index));

            error_count   <= errors;
            pending_count <= expected_results.size();
        end
    end

endmodule

[tb/nmea_sentence_capture_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_capture_test
// Drives the sentence capture block with framed NMEA sentences, noise,
// short and run-on sentences and reads of the captured buffer, under
// several tag settings and random stalls on both channels. The checker
// beside the block predicts every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module nmea_sentence_capture_test;
    import nmea_cap_pkg::*;

    localparam int BUF_DEPTH  = 128;
    localparam int TAG_LEN    = 5;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 300;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [TAG_W-1:0]     cfg_data;
    int                   error_count;
    int                   pending_count;

    bit                   quiet;
    bit                   hold_armed;
    int                   items_sent;
    int                   long_runs;
    int                   idle_cycles;
    logic [TAG_W-1:0]     want_first;
    logic [TAG_W-1:0]     want_second;

    nmea_cap_in_if  in_ch ();
    nmea_cap_out_if out_ch ();

    nmea_sentence_capture #(
        .BUF_DEPTH (BUF_DEPTH),
        .TAG_LEN   (TAG_LEN)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nmea_capture_checker #(
        .BUF_DEPTH (BUF_DEPTH),
        .TAG_LEN   (TAG_LEN)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always #5 clk = ~clk;

    // Offer one input item, with an occasional gap first; return once taken
    task automatic offer_item(input logic k, input logic [BYTE_W-1:0] b,
                              input logic [RIDX_W-1:0] ri);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= k;
        in_ch.rx_byte    <= b;
        in_ch.read_index <= ri;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_rx(input logic [BYTE_W-1:0] b);
        offer_item(KIND_RX, b, RIDX_W'($urandom_range(0, 127)));
    endtask

    task automatic send_read(input logic [RIDX_W-1:0] ri);
        offer_item(KIND_READ, BYTE_W'($urandom_range(0, 255)), ri);
    endtask

    // Send '$', the header, a random body and CR LF; no LF directly after a CR
    task automatic send_sentence(input logic [TAG_W-1:0] header, input int body_len);
        logic [BYTE_W-1:0] b;
        bit                prev_cr;
        prev_cr = 1'b0;
        send_rx(CHAR_START);
        for (int i = TAG_LEN - 1; i >= 0; i--)
            send_rx(header[8*i +: 8]);
        for (int i = 0; i < body_len; i++)
        begin
            b = ($urandom_range(0, 9) == 0) ? CHAR_CR : BYTE_W'($urandom_range(0, 255));
            if (prev_cr && b == CHAR_LF)
                b = 8'h2C;
            prev_cr = (b == CHAR_CR);
            send_rx(b);
        end
        send_rx(CHAR_CR);
        send_rx(CHAR_LF);
    endtask

    // Send '$' and a run of bytes that never forms CR LF
    task automatic send_runon(input int count);
        logic [BYTE_W-1:0] b;
        send_rx(CHAR_START);
        for (int i = 0; i < count; i++)
        begin
            b = BYTE_W'($urandom_range(0, 255));
            if (b == CHAR_CR)
                b = 8'h2E;
            send_rx(b);
        end
    endtask

    // Write one register once nothing is in flight
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [TAG_W-1:0] val);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_TAG_FIRST)
            want_first = val;
        else if (idx == REG_TAG_SECOND)
            want_second = val;
    endtask

    function automatic logic [TAG_W-1:0] random_tag();
        return {8'($urandom_range(0, 255)), 32'($urandom)};
    endfunction

    // Mixed traffic: mostly framed sentences, plus reads, noise and broken frames
    task automatic run_traffic(input int stop_at);
        int               pick;
        int               body;
        logic [TAG_W-1:0] header;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 48)
            begin
                case ($urandom_range(0, 3))
                    0:       header = want_first;
                    1:       header = want_second;
                    2:       header = random_tag();
                    default: header = want_first ^ (40'h1 << $urandom_range(0, 39));
                endcase
                body = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(0, 12);
                if (long_runs < 2 && $urandom_range(0, 59) == 0)
                begin
                    // Fill the buffer to its last position exactly
                    long_runs++;
                    body = BUF_DEPTH - TAG_LEN - 3;
                end
                send_sentence(header, body);
            end
            else if (pick < 68)
            begin
                repeat ($urandom_range(1, 4))
                    send_read(($urandom_range(0, 3) == 0) ? RIDX_W'($urandom_range(0, 127))
                                                          : RIDX_W'($urandom_range(0, 24)));
            end
            else if (pick < 83)
            begin
                repeat ($urandom_range(1, 5))
                begin
                    case ($urandom_range(0, 5))
                        0:       send_rx(CHAR_CR);
                        1:       send_rx(CHAR_LF);
                        default: send_rx(BYTE_W'($urandom_range(0, 255)));
                    endcase
                end
            end
            else if (pick < 97)
            begin
                // Short frame: CR LF before the header is complete
                send_rx(CHAR_START);
                repeat ($urandom_range(0, TAG_LEN - 1))
                    send_rx(want_second[8*$urandom_range(0, TAG_LEN - 1) +: 8]);
                send_rx(CHAR_CR);
                send_rx(CHAR_LF);
            end
            else if (long_runs < 4)
            begin
                long_runs++;
                send_runon(BUF_DEPTH - 1);
            end
        end
    endtask

    // Result side: random stalls, one long hold-off on request
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_armed)
            begin
                hold_armed = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        quiet       = 1'b0;
        hold_armed  = 1'b0;
        items_sent  = 0;
        long_runs   = 0;
        want_first  = TAG_FIRST_RST;
        want_second = TAG_SECOND_RST;
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= KIND_RX;
        in_ch.rx_byte    <= '0;
        in_ch.read_index <= '0;
        cfg_we           <= 1'b0;
        cfg_index        <= REG_TAG_FIRST;
        cfg_data         <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty reads, hunt extremes, wanted, unwanted, short frame
        send_read('0);
        send_read('1);
        send_rx(8'h00);
        send_rx(8'hFF);
        send_sentence(TAG_FIRST_RST, 0);
        send_read('0);
        send_read(RIDX_W'(7));
        send_sentence(TAG_SECOND_RST, 0);
        send_rx(CHAR_START);
        send_rx(8'h47);
        send_rx(CHAR_CR);
        send_rx(CHAR_LF);

        // Second reset tag selected
        write_reg(REG_TAG_SELECT, {random_tag() & ~40'h1} | 40'h1);
        run_traffic(items_sent + 80);

        // Random tags, first selected; block stalls under a long hold-off
        write_reg(REG_TAG_FIRST, random_tag());
        write_reg(REG_TAG_SECOND, random_tag());
        write_reg(REG_TAG_SELECT, random_tag() & ~40'h1);
        hold_armed = 1'b1;
        run_traffic(items_sent + 90);

        // Equal tags with the second selected: first tag wins, nothing captured
        write_reg(REG_TAG_SECOND, want_first);
        write_reg(REG_TAG_SELECT, 40'h1);
        run_traffic(items_sent + 60);

        // Extreme tags, each side selected in turn
        write_reg(REG_TAG_FIRST, '0);
        write_reg(REG_TAG_SECOND, '1);
        write_reg(REG_TAG_SELECT, '0);
        run_traffic(items_sent + 50);
        write_reg(REG_TAG_SELECT, '1);
        run_traffic(items_sent + 50);

        // Final part with no idling on either side
        write_reg(REG_TAG_FIRST, random_tag());
        write_reg(REG_TAG_SECOND, random_tag());
        write_reg(REG_TAG_SELECT, 40'($urandom_range(0, 1)));
        quiet = 1'b1;
        run_traffic(items_sent + 80);

        // Drain and give the verdict
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
